// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/md5_pkg.sv =====
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LAST_STEP = 6'd63;

    typedef logic [3:0][31:0] t_words;

    typedef enum logic {F_ACC, F_PAD} t_front_state;
    typedef enum logic [1:0] {B_IDLE, B_RUN, B_ADD, B_EMIT} t_back_state;

    // word write into the two-slot block store
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic       empty;
        logic       final_blk;
        logic [1:0] count;
    } t_q_status;

    function automatic logic [31:0] f_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] f_shift(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by step i
    function automatic logic [3:0] f_g(input logic [5:0] i);
        logic [3:0] n;
        logic [3:0] g;
        n = i[3:0];
        case (i[5:4])
            2'd0:    g = n;
            2'd1:    g = 4'(n + (n << 2) + 4'd1);
            2'd2:    g = 4'(n + (n << 1) + 4'd5);
            2'd3:    g = 4'((n << 3) - n);
            default: g = n;
        endcase
        return g;
    endfunction

    function automatic t_words f_init(input logic [31:0] seed);
        t_words w;
        w[0] = IV_A + 32'(seed * 32'd11);
        w[1] = IV_B + 32'(seed * 32'd71);
        w[2] = IV_C + 32'(seed * 32'd37);
        w[3] = IV_D + 32'(seed * 32'd97);
        return w;
    endfunction

endpackage

// ===== rtl/md5_byte_if.sv =====
interface md5_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, byte_value, byte_present, end_of_message, input ready);
    modport sink (input valid, byte_value, byte_present, end_of_message, output ready);
endinterface

// ===== rtl/md5_digest_if.sv =====
interface md5_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/md5_message_digest_core.sv =====
// MD5 digest engine with a seedable start.
// Input channel i_in: one transaction per message byte (byte_present) and/or
// end_of_message. A message ends with a transaction carrying end_of_message.
// Output channel o_out: four transactions per message, digest words 0..3,
// last_word on the fourth; low byte of word 0 is the first digest byte.
// i_cfg_we/i_cfg_data write the seed; this re-seeds and drops any partial
// message. Write it only while the core is idle.
// Throughput: one byte per cycle while a block slot is free. The compression
// unit works each 64-byte block as one read set-up, 64 rounds and one add;
// two block slots let filling overlap compression.
// After end_of_message the front pads one byte per cycle while a block slot
// is free, then the last block compresses; digest word 0 appears once the
// final block has been compressed and added, the rest follow one per cycle
// while o_out is ready.
// A stall on o_out holds the digest; input bytes keep flowing until both
// slots are taken. Reset (synchronous) clears the seed to zero.
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    md5_byte_if.sink      i_in,
    md5_digest_if.source  o_out,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data
);

    t_mem_wr   wr;
    t_q_status q_st;
    logic      push, push_final, pop, busy, full;

    assign full = (q_st.count + {1'b0, busy}) >= 2'd2;

    md5_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_full       (full),
        .o_wr         (wr),
        .o_push       (push),
        .o_push_final (push_final)
    );

    md5_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_final (push_final),
        .i_pop        (pop),
        .o_status     (q_st)
    );

    md5_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_q        (q_st),
        .o_pop      (pop),
        .o_busy     (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/md5_front.sv =====
module md5_front
    import md5_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    md5_byte_if.sink     i_in,
    input  logic         i_cfg_we,
    input  logic         i_full,
    output t_mem_wr      o_wr,
    output logic         o_push,
    output logic         o_push_final
);

    t_front_state r_state, n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [23:0] r_word;
    logic        r_slot;
    logic        r_pad_first;
    logic        r_len_en;

    logic       acc;
    logic       wr_en;
    logic [7:0] wr_byte;
    logic [7:0] pad_byte;
    logic [63:0] len_shift;

    assign len_shift = r_len >> {r_fill[2:0], 3'b000};

    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_BYTE;
        end else if (r_fill >= LEN_POS && r_len_en) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == F_ACC) && !i_full;
        acc = i_in.valid && i_in.ready;
        case (r_state)
            F_ACC: begin
                wr_en   = acc && i_in.byte_present;
                wr_byte = i_in.byte_value;
            end
            F_PAD: begin
                wr_en   = !i_full;
                wr_byte = pad_byte;
            end
            default: begin
                wr_en   = 1'b0;
                wr_byte = 8'h00;
            end
        endcase
        o_wr.en      = wr_en && (r_fill[1:0] == 2'd3);
        o_wr.addr    = {r_slot, r_fill[5:2]};
        o_wr.data    = {wr_byte, r_word};
        o_push       = wr_en && (r_fill == LAST_POS);
        // only the block that carries the length closes the message
        o_push_final = (r_state == F_PAD) && !r_pad_first && r_len_en;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_ACC: begin
                if (acc && i_in.end_of_message) begin
                    n_state = F_PAD;
                end
            end
            F_PAD: begin
                if (wr_en && !r_pad_first && r_len_en && r_fill == LAST_POS) begin
                    n_state = F_ACC;
                end
            end
            default: n_state = F_ACC;
        endcase
        if (i_cfg_we) begin
            n_state = F_ACC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_ACC;
            r_fill      <= '0;
            r_bits      <= '0;
            r_slot      <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_en    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fill <= '0;
                r_bits <= '0;
            end else begin
                if (wr_en) begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == LAST_POS) begin
                        r_slot <= !r_slot;
                    end
                end
                if (acc) begin
                    if (i_in.end_of_message) begin
                        r_bits      <= '0;
                        r_pad_first <= 1'b1;
                    end else if (i_in.byte_present) begin
                        r_bits <= r_bits + 64'd8;
                    end
                end
                if (r_state == F_PAD && wr_en) begin
                    if (r_pad_first) begin
                        r_pad_first <= 1'b0;
                        // 0x80 in the last byte leaves a whole fresh block for the length
                        r_len_en    <= (r_fill < LEN_POS) || (r_fill == LAST_POS);
                    end else if (r_fill == LAST_POS) begin
                        // padding wrapped into a fresh block
                        r_len_en <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (r_fill[1:0])
                2'd0:    r_word[7:0]   <= wr_byte;
                2'd1:    r_word[15:8]  <= wr_byte;
                2'd2:    r_word[23:16] <= wr_byte;
                default: r_word        <= r_word;
            endcase
        end
        if (acc && i_in.end_of_message) begin
            r_len <= r_bits + (i_in.byte_present ? 64'd8 : 64'd0);
        end
    end

endmodule

// ===== rtl/md5_queue.sv =====
module md5_queue
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_push_final,
    input  logic      i_pop,
    output t_q_status o_status
);

    logic [1:0] r_fin;
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_status.empty     = (r_cnt == 2'd0);
    assign o_status.final_blk = r_fin[r_rp];
    assign o_status.count     = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fin[r_wp] <= i_push_final;
        end
    end

endmodule

// ===== rtl/md5_back.sv =====
module md5_back
    import md5_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_wr       i_wr,
    input  t_q_status     i_q,
    output logic          o_pop,
    output logic          o_busy,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    md5_digest_if.source  o_out
);

    t_back_state r_state, n_state;
    logic [31:0] mem [32];
    logic [31:0] r_q;
    t_words      r_h;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_step;
    logic        r_slot;
    logic        r_final;
    logic [1:0]  r_idx;
    logic [31:0] r_seed;

    logic [4:0]  rd_addr;
    logic [5:0]  step_nx;
    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] t_rot;
    logic        out_acc;

    assign step_nx = r_step + 6'd1;
    assign out_acc = o_out.valid && o_out.ready;

    always_comb begin
        case (r_step[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        t     = r_a + f + r_q + f_k(r_step);
        t_rot = {t, t} << f_shift(r_step);
    end

    // outputs
    always_comb begin
        o_pop   = (r_state == B_IDLE) && !i_q.empty;
        o_busy  = (r_state != B_IDLE);
        rd_addr = (r_state == B_RUN) ? {r_slot, f_g(step_nx)} : {r_slot, f_g(6'd0)};
        o_out.valid       = (r_state == B_EMIT);
        o_out.digest_word = r_h[r_idx];
        o_out.word_index  = r_idx;
        o_out.last_word   = (r_idx == 2'd3);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_q.empty) n_state = B_RUN;
            B_RUN:  if (r_step == LAST_STEP) n_state = B_ADD;
            B_ADD:  n_state = r_final ? B_EMIT : B_IDLE;
            B_EMIT: if (out_acc && r_idx == 2'd3) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_h     <= f_init(32'd0);
            r_seed  <= '0;
            r_slot  <= 1'b0;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
                r_h    <= f_init(i_cfg_data);
            end else begin
                case (r_state)
                    B_IDLE: begin
                        if (!i_q.empty) begin
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_final <= i_q.final_blk;
                            r_step  <= '0;
                        end
                    end
                    B_RUN: begin
                        r_a    <= r_d;
                        r_d    <= r_c;
                        r_c    <= r_b;
                        r_b    <= r_b + t_rot[63:32];
                        r_step <= step_nx;
                    end
                    B_ADD: begin
                        r_h[0] <= r_h[0] + r_a;
                        r_h[1] <= r_h[1] + r_b;
                        r_h[2] <= r_h[2] + r_c;
                        r_h[3] <= r_h[3] + r_d;
                        r_slot <= !r_slot;
                        r_idx  <= '0;
                    end
                    B_EMIT: begin
                        if (out_acc) begin
                            r_idx <= r_idx + 2'd1;
                            if (r_idx == 2'd3) begin
                                r_h <= f_init(r_seed);
                            end
                        end
                    end
                    default: r_step <= r_step;
                endcase
            end
        end
    end

endmodule

// ===== rtl/md5_checker.sv =====
`include "assert_macros.svh"

module md5_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest,
    input logic [1:0]  i_index,
    input logic        i_last
);

    `ASSERT_RST(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_digest) && $stable(i_index)), "stalled digest transaction changed")
    `ASSERT_RST(a_step, i_clk, i_rst_n, (i_out_valid && i_out_ready && !i_last) |=> (i_out_valid && i_index == $past(i_index) + 2'd1), "digest words not consecutive")
    `ASSERT_RST(a_last, i_clk, i_rst_n, !i_out_valid || (i_last == (i_index == 2'd3)), "last_word flag wrong")
    `ASSERT_RST(a_first, i_clk, i_rst_n, $rose(i_out_valid) |-> (i_index == 2'd0), "digest did not start at word 0")

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_digest    (o_out.digest_word),
    .i_index     (o_out.word_index),
    .i_last      (o_out.last_word)
);

// ===== verif/md5_message_digest_core_tb.sv =====
`timescale 1ns / 100ps

module md5_message_digest_core_tb;
    import md5_pkg::*;

    typedef struct {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       end_of_message;
    } t_byte_txn;

    typedef struct {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_digest_txn;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_data;

    md5_byte_if   byte_ch ();
    md5_digest_if digest_ch ();

    md5_message_digest_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (byte_ch.sink),
        .o_out      (digest_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [7:0]  pm_block [64];
    logic [31:0] pm_chain [4];
    logic [63:0] pm_bits;
    logic [5:0]  pm_fill;
    logic [31:0] pm_seed;

    t_byte_txn   pending_bytes [$];
    t_digest_txn expected_digests [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int mismatches;

    localparam logic [31:0] T_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int T_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic md5_compress();
        logic [31:0] msg [16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        int rnd;
        for (int i = 0; i < 16; i++)
            msg[i] = {pm_block[4*i+3], pm_block[4*i+2], pm_block[4*i+1], pm_block[4*i]};
        a = pm_chain[0]; b = pm_chain[1]; c = pm_chain[2]; d = pm_chain[3];
        for (int i = 0; i < 64; i++) begin
            rnd = i / 16;
            case (rnd)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = 5 * i + 1; end
                2: begin f = b ^ c ^ d; g = 3 * i + 5; end
                default: begin f = c ^ (b | ~d); g = 7 * i; end
            endcase
            t = a + f + msg[g % 16] + T_K[i];
            a = d; d = c; c = b;
            b = b + rol(t, T_ROT[rnd * 4 + i % 4]);
        end
        pm_chain[0] += a; pm_chain[1] += b; pm_chain[2] += c; pm_chain[3] += d;
    endtask

    task automatic md5_reseed();
        pm_chain[0] = 32'h67452301 + pm_seed * 32'd11;
        pm_chain[1] = 32'hefcdab89 + pm_seed * 32'd71;
        pm_chain[2] = 32'h98badcfe + pm_seed * 32'd37;
        pm_chain[3] = 32'h10325476 + pm_seed * 32'd97;
        pm_bits = '0;
        pm_fill = '0;
    endtask

    task automatic md5_absorb(input logic [7:0] v);
        pm_block[pm_fill] = v;
        pm_fill = pm_fill + 6'd1;
        if (pm_fill == 6'd0)
            md5_compress();
    endtask

    task automatic predict_digest(input t_byte_txn tr);
        logic [63:0] len;
        t_digest_txn r;
        if (tr.byte_present) begin
            md5_absorb(tr.byte_value);
            pm_bits += 64'd8;
        end
        if (tr.end_of_message) begin
            len = pm_bits;
            md5_absorb(8'h80);
            while (pm_fill != 6'd56)
                md5_absorb(8'h00);
            for (int k = 0; k < 8; k++)
                md5_absorb(len[8*k +: 8]);
            for (int k = 0; k < 4; k++) begin
                r.digest_word = pm_chain[k];
                r.word_index  = 2'(k);
                r.last_word   = (k == 3);
                expected_digests.push_back(r);
            end
            md5_reseed();
        end
    endtask

    task automatic queue_byte(input logic [7:0] v, input bit present, input bit eom);
        t_byte_txn tr;
        tr.byte_value = v;
        tr.byte_present = present;
        tr.end_of_message = eom;
        pending_bytes.push_back(tr);
    endtask

    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
            queue_byte(8'($urandom), 1'b1, 1'b0);
        // close either with a final byte or with an empty end transaction
        if ($urandom_range(1, 0) == 1 || len == 0)
            queue_byte(8'($urandom), 1'b0, 1'b1);
        else
            queue_byte(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_digests.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pm_seed = v;
        md5_reseed();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                predict_digest(pending_bytes.pop_front());
            end
            if ((!byte_ch.valid || byte_ch.ready)) begin
                if (pending_bytes.size() > (byte_ch.valid && byte_ch.ready ? 0 : 0) &&
                    pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    byte_ch.valid          <= 1'b1;
                    byte_ch.byte_value     <= pending_bytes[0].byte_value;
                    byte_ch.byte_present   <= pending_bytes[0].byte_present;
                    byte_ch.end_of_message <= pending_bytes[0].end_of_message;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        t_digest_txn want;
        if (!i_rst_n) begin
            digest_ch.ready <= 1'b0;
        end else begin
            if (digest_ch.valid && digest_ch.ready) begin
                if (expected_digests.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest transaction: word %h idx %0d",
                                 digest_ch.digest_word, digest_ch.word_index);
                end else begin
                    want = expected_digests.pop_front();
                    if (digest_ch.digest_word !== want.digest_word ||
                        digest_ch.word_index !== want.word_index ||
                        digest_ch.last_word !== want.last_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     want.digest_word, want.word_index, want.last_word,
                                     digest_ch.digest_word, digest_ch.word_index,
                                     digest_ch.last_word);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                digest_ch.ready <= 1'b0;
            end else begin
                digest_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [31:0] seeds [4];
        mismatches = 0;
        send_idle_pct = 20;
        recv_idle_pct = 85;
        hold_off_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.byte_value = '0;
        byte_ch.byte_present = 1'b0;
        byte_ch.end_of_message = 1'b0;
        digest_ch.ready = 1'b0;
        pm_seed = '0;
        foreach (pm_block[i]) pm_block[i] = '0;
        md5_reseed();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, extremes, idle items, byte+end, 55/56 and 63/64-byte edges
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b1, 1'b1);
        queue_byte(8'h5a, 1'b1, 1'b1);
        queue_message(55);
        queue_message(63);
        wait_drained();

        seeds = '{32'hffffffff, 32'h00000001, 32'h80000000, 32'h0};
        for (int ph = 0; ph < 4; ph++) begin
            write_seed(ph == 1 ? $urandom : seeds[ph]);
            if (ph == 1) begin
                send_idle_pct = 85;
                recv_idle_pct = 20;
            end else if (ph >= 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 2)
                hold_off_cycles = 600;
            // a few short messages per seed
            for (int m = 0; m < 3; m++)
                queue_message($urandom_range(5, 0));
            wait_drained();
        end

        if (mismatches == 0 && expected_digests.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
